// ----- hw/rtl/symbolic_mode_parser_top_assert.svh -----
// ---------------------------------------------------------------------------
// Symbolic mode parser assertion macros
// Clocked same-cycle and next-cycle implications, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SYMBOLIC_MODE_PARSER_TOP_ASSERT_SVH
`define SYMBOLIC_MODE_PARSER_TOP_ASSERT_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define SMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("symbolic_mode_parser: same-cycle check failed");

// ante holds in a cycle -> cons holds in the next cycle
`define SMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("symbolic_mode_parser: next-cycle check failed");

`endif

// ----- hw/rtl/smp_pkg.sv -----
// ---------------------------------------------------------------------------
// Symbolic mode parser package
// Parser phases, operator codes, character codes, permission masks, state and action types, helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smp_pkg;

  localparam logic [2:0] PH_DIGITS    = 3'd0;
  localparam logic [2:0] PH_WHO       = 3'd1;
  localparam logic [2:0] PH_OPSTART   = 3'd2;
  localparam logic [2:0] PH_PERMS     = 3'd3;
  localparam logic [2:0] PH_AFTERCOPY = 3'd4;
  localparam logic [2:0] PH_ERROR     = 3'd5;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_XU    = 8'h58;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam logic [11:0] WHO_U    = 12'o5700;
  localparam logic [11:0] WHO_G    = 12'o2070;
  localparam logic [11:0] WHO_O    = 12'o0007;
  localparam logic [11:0] ALL_BITS = 12'o7777;
  localparam logic [11:0] PERM_R   = 12'o0444;
  localparam logic [11:0] PERM_W   = 12'o0222;
  localparam logic [11:0] PERM_X   = 12'o0111;
  localparam logic [11:0] PERM_S   = 12'o6000;
  localparam logic [11:0] PERM_T   = 12'o1000;
  localparam logic [15:0] SETGID   = 16'o02000;

  localparam logic [15:0] BASE_MODE_RST    = 16'd0;
  localparam logic [11:0] DEFAULT_MASK_RST = 12'd18;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] running_mode;
    logic [15:0] octal_value;
    logic [11:0] who_bits;
    logic [11:0] protected_bits;
    logic [1:0]  pending_op;
    logic [11:0] perm_bits;
    logic        setgid_touched;
  } state_t;

  typedef struct packed {
    logic [15:0] running_mode;
    logic        touched;
  } action_t;

  function automatic logic [1:0] op_of(input logic [7:0] c);
    logic [1:0] op;
    op = OP_NONE;
    if (c == CH_PLUS) op = OP_ADD;
    else if (c == CH_MINUS) op = OP_SUB;
    else if (c == CH_EQ) op = OP_SET;
    return op;
  endfunction

  function automatic action_t apply_action(input logic [1:0] op, input logic [11:0] b,
                                           input logic [11:0] who, input logic [11:0] prot,
                                           input logic [15:0] rm);
    action_t    r;
    logic [11:0] eff;
    eff = b & who & ~prot;
    r.running_mode = rm;
    r.touched = 1'b0;
    case (op)
      OP_ADD: begin
        r.running_mode = rm | {4'd0, eff};
        r.touched = b[10];
      end
      OP_SUB: begin
        r.running_mode = rm & ~{4'd0, eff};
        r.touched = b[10];
      end
      OP_SET: begin
        r.running_mode = (rm & ~{4'd0, who}) | {4'd0, eff};
      end
      default: begin
        r.running_mode = rm;
      end
    endcase
    return r;
  endfunction

  function automatic logic [15:0] lock_rule(input logic [15:0] base);
    logic [15:0] m;
    m = base;
    if ((base[15:12] != 4'b0100) && base[10] && !base[3]) m = base & ~SETGID;
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/smp_step.sv -----
// ---------------------------------------------------------------------------
// Symbolic mode parser step
// Next parser state and end-of-text result for one character.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smp_step (
  input  smp_pkg::state_t cur,
  input  logic [7:0]      ch,
  input  logic            is_end,
  input  logic [15:0]     base_mode,
  input  logic [11:0]     default_mask,
  output smp_pkg::state_t nxt,
  output logic [15:0]     res_mode,
  output logic            res_bad
);
  import smp_pkg::*;

  function automatic state_t clause_start(input state_t s);
    state_t r;
    r = s;
    r.who_bits = '0;
    r.protected_bits = '0;
    r.pending_op = OP_NONE;
    r.perm_bits = '0;
    r.phase = PH_WHO;
    return r;
  endfunction

  function automatic state_t who_step(input state_t s, input logic [7:0] c,
                                      input logic [11:0] dmask);
    state_t     r;
    logic [1:0] op;
    r = s;
    op = op_of(c);
    if (c == CH_U) r.who_bits = s.who_bits | WHO_U;
    else if (c == CH_G) r.who_bits = s.who_bits | WHO_G;
    else if (c == CH_O) r.who_bits = s.who_bits | WHO_O;
    else if (c == CH_A) r.who_bits = s.who_bits | ALL_BITS;
    else if (op != OP_NONE) begin
      if (s.who_bits == '0) begin
        r.who_bits = ALL_BITS;
        r.protected_bits = dmask;
      end
      r.pending_op = op;
      r.perm_bits = '0;
      r.phase = PH_OPSTART;
    end else if (c == CH_COMMA) begin
      r = clause_start(s);
    end else begin
      r.phase = PH_ERROR;
    end
    return r;
  endfunction

  function automatic state_t perms_step(input state_t s, input logic [7:0] c,
                                        input logic [15:0] base);
    state_t      r;
    logic [1:0]  op;
    logic [11:0] bits;
    logic        hit;
    action_t     ap;
    r = s;
    op = op_of(c);
    hit = 1'b1;
    bits = '0;
    case (c)
      CH_R:  bits = PERM_R;
      CH_W:  bits = PERM_W;
      CH_X:  bits = PERM_X;
      CH_XU: bits = ((base[15:12] == 4'b0100) || (base[8:0] & 9'o111) != '0) ? PERM_X : '0;
      CH_L:  bits = '0;
      CH_S:  bits = PERM_S;
      CH_T:  bits = PERM_T;
      default: hit = 1'b0;
    endcase
    ap = apply_action(s.pending_op, s.perm_bits, s.who_bits, s.protected_bits,
                      s.running_mode);
    if (hit) begin
      r.perm_bits = s.perm_bits | bits;
      r.phase = PH_PERMS;
    end else if (op != OP_NONE) begin
      r.running_mode = ap.running_mode;
      r.setgid_touched = s.setgid_touched | ap.touched;
      r.perm_bits = '0;
      r.pending_op = op;
      r.phase = PH_OPSTART;
    end else if (c == CH_COMMA) begin
      r.running_mode = ap.running_mode;
      r.setgid_touched = s.setgid_touched | ap.touched;
      r = clause_start(r);
    end else begin
      r.phase = PH_ERROR;
    end
    return r;
  endfunction

  state_t      w;
  logic [1:0]  op;
  logic [2:0]  src;
  action_t     ap;
  action_t     ap_copy;
  logic [15:0] nm;
  logic        touched;

  always_comb begin
    op = op_of(ch);
    nxt = cur;
    res_mode = '0;
    res_bad = 1'b0;
    nm = '0;
    touched = cur.setgid_touched;
    w = clause_start(cur);
    w.running_mode = lock_rule(base_mode);
    case (ch)
      CH_U:    src = cur.running_mode[8:6];
      CH_G:    src = cur.running_mode[5:3];
      default: src = cur.running_mode[2:0];
    endcase
    ap = apply_action(cur.pending_op, cur.perm_bits, cur.who_bits, cur.protected_bits,
                      cur.running_mode);
    ap_copy = apply_action(cur.pending_op, {3'd0, src, src, src}, cur.who_bits,
                           cur.protected_bits, cur.running_mode);
    if (is_end) begin
      if (cur.phase == PH_ERROR) begin
        res_bad = 1'b1;
      end else begin
        if (cur.phase == PH_DIGITS) begin
          nm = cur.octal_value;
        end else if (cur.phase == PH_OPSTART || cur.phase == PH_PERMS) begin
          nm = ap.running_mode;
          touched = cur.setgid_touched | ap.touched;
        end else begin
          nm = cur.running_mode;
        end
        if (base_mode[14] && !touched) nm = (nm & ~SETGID) | (base_mode & SETGID);
        res_mode = nm;
      end
      nxt.phase = PH_DIGITS;
      nxt.running_mode = lock_rule(base_mode);
      nxt.octal_value = '0;
      nxt.who_bits = '0;
      nxt.protected_bits = '0;
      nxt.pending_op = OP_NONE;
      nxt.perm_bits = '0;
      nxt.setgid_touched = 1'b0;
    end else begin
      case (cur.phase)
        PH_DIGITS: begin
          if (ch >= CH_ZERO && ch <= CH_SEVEN) begin
            nxt.octal_value = {cur.octal_value[12:0], ch[2:0]};
          end else begin
            nxt = who_step(w, ch, default_mask);
          end
        end
        PH_WHO: nxt = who_step(cur, ch, default_mask);
        PH_OPSTART: begin
          if (ch == CH_U || ch == CH_G || ch == CH_O) begin
            nxt.running_mode = ap_copy.running_mode;
            nxt.setgid_touched = cur.setgid_touched | ap_copy.touched;
            nxt.pending_op = OP_NONE;
            nxt.perm_bits = '0;
            nxt.phase = PH_AFTERCOPY;
          end else begin
            nxt = perms_step(cur, ch, base_mode);
          end
        end
        PH_PERMS: nxt = perms_step(cur, ch, base_mode);
        PH_AFTERCOPY: begin
          if (op != OP_NONE) begin
            nxt.pending_op = op;
            nxt.perm_bits = '0;
            nxt.phase = PH_OPSTART;
          end else if (ch == CH_COMMA) begin
            nxt = clause_start(cur);
          end else begin
            nxt.phase = PH_ERROR;
          end
        end
        default: nxt = cur;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/symbolic_mode_parser_top.sv -----
// ---------------------------------------------------------------------------
// Symbolic mode parser
// Streams a permission-mode text and returns the resulting mode on its end.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one character per transfer in s_tdata; s_tlast high marks
//   the end of the text and carries no character.
//   m_* returns one transfer per end item: m_tdata is the new mode, m_tuser
//   flags a syntax error (m_tdata is then zero).
//   cfg_* writes base_mode (index 0) and default_mask (index 1); the port is
//   always ready. Write only between texts.
//   The result is registered and valid in the cycle after the end item is accepted.
//   Throughput: one character per cycle while s_tready is high; the parser state is updated by one
//   level of mask logic per transfer.
//   Stall: the result register holds while m_tready is low and s_tready
//   stays high only while that register is empty or being drained.
//   Reset: base_mode 0, default_mask 18, parser at the start of a text,
//   no result pending.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module symbolic_mode_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] new_mode
  output logic        m_tuser,   // [0] bad_syntax
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import smp_pkg::*;

  `include "symbolic_mode_parser_top_assert.svh"

  localparam logic CFG_BASE_MODE    = 1'b0;
  localparam logic CFG_DEFAULT_MASK = 1'b1;

  logic [15:0] base_mode;
  logic [11:0] default_mask;
  state_t      state;
  state_t      state_next;
  logic [15:0] res_mode;
  logic        res_bad;
  logic        out_valid;
  logic [15:0] out_mode;
  logic        out_bad;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign s_tready  = !out_valid || m_tready;
  assign in_fire   = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_mode;
  assign m_tuser   = out_bad;

  smp_step u_step (
    .cur          (state),
    .ch           (s_tdata),
    .is_end       (s_tlast),
    .base_mode    (base_mode),
    .default_mask (default_mask),
    .nxt          (state_next),
    .res_mode     (res_mode),
    .res_bad      (res_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode <= BASE_MODE_RST;
      default_mask <= DEFAULT_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BASE_MODE:    base_mode <= cfg_data;
        CFG_DEFAULT_MASK: default_mask <= cfg_data[11:0];
        default:          base_mode <= base_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= PH_DIGITS;
      state.running_mode <= '0;
      state.octal_value <= '0;
      state.who_bits <= '0;
      state.protected_bits <= '0;
      state.pending_op <= OP_NONE;
      state.perm_bits <= '0;
      state.setgid_touched <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && s_tlast) begin
      out_valid <= 1'b1;
    end else if (out_valid && m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && s_tlast) begin
      out_mode <= res_mode;
      out_bad <= res_bad;
    end
  end

  `SMP_ASSERT_NEXT(a_end_gives_result, in_fire && s_tlast, m_tvalid)
  `SMP_ASSERT_NEXT(a_end_restarts, in_fire && s_tlast, state.phase == PH_DIGITS)
  `SMP_ASSERT_NOW(a_error_zero_mode, m_tvalid && m_tuser, m_tdata == '0)
  `SMP_ASSERT_NEXT(a_error_sticks, in_fire && !s_tlast && state.phase == PH_ERROR,
                   state.phase == PH_ERROR)

endmodule

`default_nettype wire
